// ===== sv/rbst_pkg.sv =====
package rbst_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned FracW    = 16;
  localparam int unsigned ScaleW   = 32;
  localparam int unsigned ScaleFrac = 30;
  localparam int unsigned FarW     = 31;
  localparam int unsigned ProdW    = 2 * CoordW + 1;
  localparam int unsigned Axes     = 3;

  // 1 + 2^-30 in Q2.30
  localparam logic [ScaleW-1:0] FarScaleReset = ScaleW'(32'd1073741825);

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [CoordW:0]   diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic [FarW-1:0]          far_t;
  typedef logic [ScaleW-1:0]        scale_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    OUTCOME_MISS    = 2'd0,
    OUTCOME_INSIDE  = 2'd1,
    OUTCOME_OUTSIDE = 2'd2
  } outcome_e;

  typedef struct packed {
    op_e    op;
    coord_t first_x;
    coord_t first_y;
    coord_t first_z;
    coord_t second_x;
    coord_t second_y;
    coord_t second_z;
    far_t   far_limit;
  } item_t;

  typedef struct packed {
    outcome_e outcome;
  } result_t;

  // Load enables of the lane stages
  typedef struct packed {
    logic prod;
    logic slab;
    logic sort;
    logic scale;
    logic exit;
  } lane_adv_t;

  // Shift right toward zero, then saturate to a signed coordinate
  function automatic coord_t shift_sat(input prod_t p, input int unsigned sh);
    prod_t bias;
    prod_t q;
    bias = p[ProdW-1] ? ((prod_t'(1) << sh) - prod_t'(1)) : '0;
    q = (p + bias) >>> sh;
    if (q[ProdW-1:CoordW-1] == '0 || q[ProdW-1:CoordW-1] == '1) begin
      return q[CoordW-1:0];
    end else if (q[ProdW-1]) begin
      return coord_t'({1'b1, {(CoordW-1){1'b0}}});
    end else begin
      return coord_t'({1'b0, {(CoordW-1){1'b1}}});
    end
  endfunction

endpackage

// ===== sv/rbst_item_if.sv =====
interface rbst_item_if;
  logic          valid;
  logic          ready;
  rbst_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rbst_result_if.sv =====
interface rbst_result_if;
  logic              valid;
  logic              ready;
  rbst_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rbst_cfg_if.sv =====
interface rbst_cfg_if;
  logic             valid;
  logic             ready;
  rbst_pkg::scale_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rbst_lane.sv =====
module rbst_lane (
  input  logic                clk_i,
  input  rbst_pkg::lane_adv_t adv_i,
  input  rbst_pkg::diff_t     diff_lo_i,
  input  rbst_pkg::diff_t     diff_hi_i,
  input  rbst_pkg::coord_t    inv_i,
  input  rbst_pkg::scale_t    scale_i,
  output rbst_pkg::coord_t    t_near_o,
  output rbst_pkg::coord_t    t_far_o
);
  import rbst_pkg::*;

  prod_t  prod_lo_q, prod_hi_q;
  coord_t ta_q, tb_q;
  coord_t tn_sort_q, tf_sort_q;
  coord_t tn_scale_q;
  prod_t  prod_f_q;
  coord_t tn_exit_q, tf_exit_q;

  always_ff @(posedge clk_i) begin
    if (adv_i.prod) begin
      prod_lo_q <= diff_lo_i * inv_i;
      prod_hi_q <= diff_hi_i * inv_i;
    end
    if (adv_i.slab) begin
      ta_q <= shift_sat(prod_lo_q, FracW);
      tb_q <= shift_sat(prod_hi_q, FracW);
    end
    if (adv_i.sort) begin
      tn_sort_q <= (ta_q < tb_q) ? ta_q : tb_q;
      tf_sort_q <= (ta_q < tb_q) ? tb_q : ta_q;
    end
    if (adv_i.scale) begin
      tn_scale_q <= tn_sort_q;
      prod_f_q   <= tf_sort_q * $signed({1'b0, scale_i});
    end
    if (adv_i.exit) begin
      tn_exit_q <= tn_scale_q;
      tf_exit_q <= shift_sat(prod_f_q, ScaleFrac);
    end
  end

  assign t_near_o = tn_exit_q;
  assign t_far_o  = tf_exit_q;

endmodule

// ===== sv/ray_box_slab_test.sv =====
// Channel  Dir  Payload                                   Accept
// in_i     in   op, first_x/y/z, second_x/y/z, far_limit  valid && ready
// out_o    out  outcome                                   valid && ready
// cfg_i    in   far_scale                                 valid && ready (always ready)
//
// One item per cycle while out_o is not stalled; a test item gives its outcome once it has passed every stage.
// The depth is set by the 33x32 multiplies with their saturating shifts.
// A load item updates the stored ray at acceptance and gives no result.
// Reset clears the stored ray and valid bits and sets far_scale to 1 + 2^-30.
// Each stage holds while the one after it is full and stalled; bubbles close up.
module ray_box_slab_test (
  input  logic clk_i,
  input  logic rst_ni,
  rbst_item_if.sink     in_i,
  rbst_result_if.source out_o,
  rbst_cfg_if.sink      cfg_i
);
  import rbst_pkg::*;

  localparam int unsigned Stages = 8;

  coord_t ray_org_q [Axes];
  coord_t ray_inv_q [Axes];
  far_t   ray_fb_q;
  scale_t far_scale_q;

  logic [Stages:1]   en;
  logic [Stages:1]   valid_q;
  logic              in_acc, test_acc, load_acc;

  coord_t lo [Axes];
  coord_t hi [Axes];
  logic   inside_d;

  diff_t  diff_lo_q [Axes];
  diff_t  diff_hi_q [Axes];
  coord_t inv_q [Axes];
  logic   inside_q [1:6];
  far_t   fb_q [1:6];

  lane_adv_t adv;
  coord_t    t_near [Axes];
  coord_t    t_far [Axes];

  coord_t near_d, far_d;
  coord_t near_q, far_q;
  logic   inside7_q;
  result_t out_q;

  assign lo[0] = in_i.data.first_x;
  assign lo[1] = in_i.data.first_y;
  assign lo[2] = in_i.data.first_z;
  assign hi[0] = in_i.data.second_x;
  assign hi[1] = in_i.data.second_y;
  assign hi[2] = in_i.data.second_z;

  // Stage enables: a stage loads when empty or when its contents move on
  always_comb begin
    en[Stages] = !valid_q[Stages] || out_o.ready;
    for (int k = Stages - 1; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[1];
  assign in_acc     = in_i.valid && en[1];
  assign test_acc   = in_acc && (in_i.data.op == OP_TEST);
  assign load_acc   = in_acc && (in_i.data.op == OP_LOAD);
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < Axes; a++) begin
        ray_org_q[a] <= '0;
        ray_inv_q[a] <= '0;
      end
      ray_fb_q    <= '0;
      far_scale_q <= FarScaleReset;
    end else begin
      if (load_acc) begin
        for (int a = 0; a < Axes; a++) begin
          ray_org_q[a] <= lo[a];
          ray_inv_q[a] <= hi[a];
        end
        ray_fb_q <= in_i.data.far_limit;
      end
      if (cfg_i.valid) begin
        far_scale_q <= cfg_i.data;
      end
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[1]) begin
        valid_q[1] <= test_acc;
      end
      for (int k = 2; k <= Stages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_comb begin
    inside_d = 1'b1;
    for (int a = 0; a < Axes; a++) begin
      if (!(ray_org_q[a] > lo[a] && ray_org_q[a] < hi[a])) begin
        inside_d = 1'b0;
      end
    end
  end

  // Stage 1: slab offsets against the ray as it stood at acceptance
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int a = 0; a < Axes; a++) begin
        diff_lo_q[a] <= diff_t'(lo[a]) - diff_t'(ray_org_q[a]);
        diff_hi_q[a] <= diff_t'(hi[a]) - diff_t'(ray_org_q[a]);
        inv_q[a]     <= ray_inv_q[a];
      end
      inside_q[1] <= inside_d;
      fb_q[1]     <= ray_fb_q;
    end
    for (int k = 2; k <= 6; k++) begin
      if (en[k]) begin
        inside_q[k] <= inside_q[k-1];
        fb_q[k]     <= fb_q[k-1];
      end
    end
  end

  assign adv.prod  = en[2];
  assign adv.slab  = en[3];
  assign adv.sort  = en[4];
  assign adv.scale = en[5];
  assign adv.exit  = en[6];

  for (genvar a = 0; a < Axes; a++) begin : g_lane
    rbst_lane u_lane (
      .clk_i     (clk_i),
      .adv_i     (adv),
      .diff_lo_i (diff_lo_q[a]),
      .diff_hi_i (diff_hi_q[a]),
      .inv_i     (inv_q[a]),
      .scale_i   (far_scale_q),
      .t_near_o  (t_near[a]),
      .t_far_o   (t_far[a])
    );
  end

  // Narrow the interval [0, far] by each slab
  always_comb begin
    near_d = '0;
    far_d  = coord_t'({1'b0, fb_q[6]});
    for (int a = 0; a < Axes; a++) begin
      if (t_near[a] > near_d) begin
        near_d = t_near[a];
      end
      if (t_far[a] < far_d) begin
        far_d = t_far[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      near_q    <= near_d;
      far_q     <= far_d;
      inside7_q <= inside_q[6];
    end
    if (en[8]) begin
      if (inside7_q) begin
        out_q.outcome <= OUTCOME_INSIDE;
      end else if (near_q > far_q) begin
        out_q.outcome <= OUTCOME_MISS;
      end else begin
        out_q.outcome <= OUTCOME_OUTSIDE;
      end
    end
  end

  assign out_o.valid = valid_q[Stages];
  assign out_o.data  = out_q;

  a_load_no_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en[1] |=> (valid_q[1] == $past(test_acc)))
    else $error("stage 1 valid does not follow an accepted test item");

  a_inside_outcome : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[7] && inside7_q && en[8]) |=> (out_o.data.outcome == OUTCOME_INSIDE))
    else $error("origin inside box but outcome is not an inside hit");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready && valid_q[7]) |=> (valid_q[7] && $stable(near_q)))
    else $error("stage 7 item lost under output stall");

  a_ray_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load_acc |=> $stable(ray_fb_q))
    else $error("ray far bound changed without a load item");

endmodule
